@@ src/ffpa_pkg.sv @@
package ffpa_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_SHRINK = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] request_bytes;
    logic [15:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] user_offset;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the item, reset scan index
    logic step;      // advance scan index
    logic read;      // issue table read at scan index
    logic read_nb;   // read the neighbor that a shift moves (insert: idx-1, free: idx+1)
    logic seek;      // mark insertion point idx+1, jump scan index to the entry count
    logic shift;     // move one entry (insert: down, free: up)
    logic write_new; // write new entry at insertion point
    logic write_len; // rewrite length at match
    logic cnt_inc;
    logic cnt_dec;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic scan_done;   // scan index reached last entry to examine
    logic hit;         // gap fits / offset matches (from registered read)
    logic append_ok;
    logic shift_done;
    logic empty;
  } dp_stat_t;

endpackage

@@ src/first_fit_pool_allocator.sv @@
// first_fit_pool_allocator: first-fit allocator over a byte pool with an ordered block table.
// Pulse start with in_item while busy is low; exactly one result follows, on out_item for one
// cycle with out_valid high, in the cycle in which busy falls. The receiver cannot stall it.
// An item keeps busy high while the table memory is scanned entry by entry (read, then
// compare) and then entries are moved one by one (read the neighbor, write it) to open or
// close a slot; freeing the first or last block of a full table takes longest. The user must
// write pool_size via cfg_we/cfg_data only while no item is in flight; it is not enforced.
module first_fit_pool_allocator #(
  parameter int POOL_BYTES   = 65536,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffpa_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ffpa_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_data
);
  import ffpa_pkg::*;

  logic [16:0] pool_size_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] found_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= 17'd65536;
    end else if (cfg_we) begin
      pool_size_r <= cfg_data;
    end
  end

  ffpa_datapath #(
    .POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES), .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk, .rst_n, .in_item, .pool_size_r, .cmd, .stat, .found_offset
  );

  ffpa_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_kind(in_item.kind), .stat, .found_offset,
    .cmd, .busy, .out_valid, .out_item
  );

endmodule

module ffpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_kind,
  input  ffpa_pkg::dp_stat_t  stat,
  input  logic [15:0]         found_offset,
  output ffpa_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                out_valid,
  output ffpa_pkg::out_item_t out_item
);
  import ffpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_INS_RD,
    S_INS_WR,
    S_INS_NEW,
    S_DEL_RD,
    S_DEL_WR
  } state_t;

  state_t      state_r, state_nxt;
  kind_t       kind_r;
  logic [15:0] off_r, off_nxt;
  logic        out_valid_r, done_nxt;
  out_item_t   out_item_r;
  status_t     st_nxt;
  logic [15:0] res_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    off_nxt   = off_r;
    done_nxt  = 1'b0;
    st_nxt    = ST_UNKNOWN;
    res_nxt   = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (kind_r)
          KIND_ALLOC: begin
            if (stat.full) begin
              done_nxt  = 1'b1;
              st_nxt    = ST_FULL;
              state_nxt = S_IDLE;
            end else if (stat.empty) begin
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
              if (stat.append_ok) begin
                cmd.write_new = 1'b1;
                cmd.cnt_inc   = 1'b1;
                st_nxt        = ST_OK;
                res_nxt       = found_offset;
              end else begin
                st_nxt = ST_NOSPACE;
              end
            end else begin
              cmd.read  = 1'b1;
              state_nxt = S_EVAL;
            end
          end
          KIND_SHRINK, KIND_FREE: begin
            if (stat.empty) begin
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.read  = 1'b1;
              state_nxt = S_EVAL;
            end
          end
          default: begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (kind_r == KIND_ALLOC) begin
          if ((!stat.scan_done && stat.hit) || (stat.scan_done && stat.append_ok)) begin
            cmd.seek  = 1'b1;
            state_nxt = S_INS_RD;
          end else if (!stat.scan_done) begin
            cmd.step  = 1'b1;
            state_nxt = S_READ;
          end else begin
            done_nxt  = 1'b1;
            st_nxt    = ST_NOSPACE;
            state_nxt = S_IDLE;
          end
        end else if (stat.hit) begin
          if (kind_r == KIND_SHRINK) begin
            cmd.write_len = 1'b1;
            done_nxt      = 1'b1;
            st_nxt        = ST_OK;
            res_nxt       = found_offset;
            state_nxt     = S_IDLE;
          end else begin
            off_nxt   = found_offset;
            state_nxt = S_DEL_RD;
          end
        end else if (!stat.scan_done) begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_RD: begin
        cmd.read_nb = 1'b1;
        state_nxt   = stat.shift_done ? S_INS_NEW : S_INS_WR;
      end
      S_INS_WR: begin
        cmd.shift = 1'b1;
        state_nxt = S_INS_RD;
      end
      S_INS_NEW: begin
        cmd.write_new = 1'b1;
        cmd.cnt_inc   = 1'b1;
        done_nxt      = 1'b1;
        st_nxt        = ST_OK;
        res_nxt       = found_offset;
        state_nxt     = S_IDLE;
      end
      S_DEL_RD: begin
        if (stat.scan_done) begin
          cmd.cnt_dec = 1'b1;
          done_nxt    = 1'b1;
          st_nxt      = ST_OK;
          res_nxt     = off_r;
          state_nxt   = S_IDLE;
        end else begin
          cmd.read_nb = 1'b1;
          state_nxt   = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.shift = 1'b1;
        state_nxt = S_DEL_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_NONE;
      off_r       <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      state_r <= state_nxt;
      off_r   <= off_nxt;
      if (cmd.load) begin
        kind_r <= kind_t'(in_kind);
      end
      out_valid_r            <= done_nxt;
      out_item_r.status      <= st_nxt;
      out_item_r.user_offset <= res_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE));
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid);
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy);
  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.full);
  a_dec_some: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !stat.empty);

endmodule

@@ src/ffpa_datapath.sv @@
module ffpa_datapath #(
  parameter int POOL_BYTES   = 65536,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffpa_pkg::in_item_t in_item,
  input  logic [16:0]        pool_size_r,
  input  ffpa_pkg::dp_cmd_t  cmd,
  output ffpa_pkg::dp_stat_t stat,
  output logic [15:0]        found_offset
);
  import ffpa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(POOL_BYTES + 1) + 2;

  logic [15:0] mem_start [MAX_BLOCKS];
  logic [15:0] mem_len   [MAX_BLOCKS];

  in_item_t      item_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;
  logic [15:0]   rd_start_r, rd_len_r, rd_next_r;
  logic [AW-1:0] end_w, need_w, lim_w, gap_w;
  logic [IW-1:0] ra, rb, nb, rd_a, wa;
  logic          is_alloc;
  logic          wr_en;
  logic [15:0]   wr_start, wr_len;

  assign is_alloc = (item_r.kind == KIND_ALLOC);
  assign ra = idx_r[IW-1:0];
  assign rb = (idx_r + CW'(1) >= CW'(MAX_BLOCKS)) ? ra : IW'(idx_r + CW'(1));
  assign nb = is_alloc ? IW'(idx_r - CW'(1)) : IW'(idx_r + CW'(1));
  assign rd_a = cmd.read_nb ? nb : ra;

  // registered table reads: entry i (or the neighbor to move) and the start of entry i+1
  always_ff @(posedge clk) begin
    if (cmd.read || cmd.read_nb) begin
      rd_start_r <= mem_start[rd_a];
      rd_len_r   <= mem_len[rd_a];
      rd_next_r  <= mem_start[rb];
    end
    if (wr_en) begin
      mem_start[wa] <= wr_start;
      mem_len[wa]   <= wr_len;
    end
  end

  // shift: insert moves entry idx-1 to idx (walking down), free moves idx+1 to idx
  always_comb begin
    wr_en    = 1'b0;
    wa       = ra;
    wr_start = rd_start_r;
    wr_len   = rd_len_r;
    if (cmd.shift) begin
      wr_en = 1'b1;
    end else if (cmd.write_new) begin
      wr_en    = 1'b1;
      wr_start = stat.empty ? 16'd0 : end_w[15:0];
      wr_len   = item_r.request_bytes;
    end else if (cmd.write_len) begin
      wr_en    = 1'b1;
      wr_start = rd_start_r;
      wr_len   = item_r.request_bytes;
    end
  end

  assign end_w  = AW'(rd_start_r) + AW'(HEADER_BYTES) + AW'(rd_len_r);
  assign need_w = AW'(item_r.request_bytes) + AW'(HEADER_BYTES);
  assign lim_w  = (AW'(pool_size_r) > AW'(POOL_BYTES)) ? AW'(POOL_BYTES) : AW'(pool_size_r);
  assign gap_w  = AW'(rd_next_r) - end_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      idx_r  <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + CW'(1);
    end else if (cmd.seek) begin
      idx_r <= cnt_r;
    end else if (cmd.shift && is_alloc) begin
      idx_r <= idx_r - CW'(1);
    end else if (cmd.shift) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.seek) begin
      pos_r <= idx_r + CW'(1);
    end
  end

  always_comb begin
    stat.full  = (cnt_r == CW'(MAX_BLOCKS));
    stat.empty = (cnt_r == '0);
    if (is_alloc) begin
      stat.scan_done = (idx_r + CW'(1) >= cnt_r);
      stat.hit = (AW'(rd_next_r) > end_w) && (gap_w >= need_w);
    end else begin
      stat.scan_done = (idx_r + CW'(1) >= cnt_r);
      stat.hit = ((rd_start_r + 16'(HEADER_BYTES)) == item_r.block_offset);
    end
    stat.append_ok  = stat.empty ? (AW'(0) < lim_w && lim_w >= need_w)
                                 : (end_w < lim_w && lim_w - end_w >= need_w);
    stat.shift_done = (idx_r == pos_r);
  end

  assign found_offset = !is_alloc  ? (rd_start_r + 16'(HEADER_BYTES)) :
                        stat.empty ? 16'(HEADER_BYTES) : 16'(end_w + AW'(HEADER_BYTES));

endmodule
